// ===== rtl/core/dvc_pkg.sv =====
package dvc_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int CLOCK_WIDTH = 32;
    localparam int ADDR_W = $clog2(MAX_PROCESSES);
    localparam int COUNT_W = ADDR_W + 1;
    localparam int INDEX_W = 5;
    localparam int KIND_W = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 5;

    typedef logic [CLOCK_WIDTH-1:0] clock_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [KIND_W-1:0] kind_t;

    localparam clock_t CLOCK_MAX = '1;

    localparam kind_t KIND_INTERNAL = 2'd0;
    localparam kind_t KIND_SEND = 2'd1;
    localparam kind_t KIND_FIRST_PAIR = 2'd2;
    localparam kind_t KIND_NEXT_PAIR = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_OWN_INDEX = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_COUNT = 1'd1;

    localparam index_t OWN_INDEX_RESET = 5'd1;
    localparam index_t PROCESS_COUNT_RESET = 5'd16;

    typedef struct packed {
        kind_t  kind;
        index_t peer_index;
        index_t pair_index;
        clock_t pair_value;
    } request_t;

    typedef struct packed {
        index_t entry_index;
        clock_t entry_value;
        logic   last;
    } result_t;

    typedef struct packed {
        clock_t value;
        clock_t update_time;
    } entry_t;

    typedef struct packed {
        addr_t  a_raddr;
        logic   a_we;
        addr_t  a_waddr;
        entry_t a_wdata;
        addr_t  b_raddr;
        logic   b_we;
        addr_t  b_waddr;
        clock_t b_wdata;
    } store_req_t;

    function automatic logic index_ok(input index_t idx);
        return (idx != '0) && (int'(idx) <= MAX_PROCESSES);
    endfunction

    function automatic addr_t index_to_addr(input index_t idx);
        return addr_t'(idx - INDEX_W'(1));
    endfunction

    function automatic index_t addr_to_index(input addr_t addr);
        return INDEX_W'(addr) + INDEX_W'(1);
    endfunction

    function automatic count_t count_limit(input index_t count);
        if (int'(count) > MAX_PROCESSES)
        begin
            return COUNT_W'(MAX_PROCESSES);
        end
        return COUNT_W'(count);
    endfunction

    function automatic clock_t sat_inc(input clock_t v);
        return (v == CLOCK_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/core/dvc_ram.sv =====
module dvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/dvc_store.sv =====
module dvc_store (
    input  logic                clk,
    input  logic                rst_n,
    input  dvc_pkg::store_req_t req,
    output dvc_pkg::entry_t     a_rdata,
    output dvc_pkg::clock_t     b_rdata
);
    import dvc_pkg::*;

    // Rows never written read as zero, matching the cleared state after reset.
    logic [MAX_PROCESSES-1:0] a_valid_reg;
    logic [MAX_PROCESSES-1:0] a_valid_next;
    logic [MAX_PROCESSES-1:0] b_valid_reg;
    logic [MAX_PROCESSES-1:0] b_valid_next;
    logic                     a_rvalid_reg;
    logic                     b_rvalid_reg;
    entry_t                   a_raw;
    clock_t                   b_raw;

    dvc_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(MAX_PROCESSES)
    ) u_vector_ram (
        .clk   (clk),
        .we    (req.a_we),
        .waddr (req.a_waddr),
        .wdata (req.a_wdata),
        .raddr (req.a_raddr),
        .rdata (a_raw)
    );

    dvc_ram #(
        .WIDTH(CLOCK_WIDTH),
        .DEPTH(MAX_PROCESSES)
    ) u_send_ram (
        .clk   (clk),
        .we    (req.b_we),
        .waddr (req.b_waddr),
        .wdata (req.b_wdata),
        .raddr (req.b_raddr),
        .rdata (b_raw)
    );

    always_comb
    begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        if (req.a_we)
        begin
            a_valid_next[req.a_waddr] = 1'b1;
        end
        if (req.b_we)
        begin
            b_valid_next[req.b_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= '0;
            b_valid_reg  <= '0;
            a_rvalid_reg <= 1'b0;
            b_rvalid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg  <= a_valid_next;
            b_valid_reg  <= b_valid_next;
            a_rvalid_reg <= a_valid_reg[req.a_raddr];
            b_rvalid_reg <= b_valid_reg[req.b_raddr];
        end
    end

    assign a_rdata = a_rvalid_reg ? a_raw : '0;
    assign b_rdata = b_rvalid_reg ? b_raw : '0;

endmodule

// ===== rtl/core/differential_vector_clock.sv =====
// A request is taken at a rising edge with start high and busy low. An internal event, or a
// send to a peer out of range, passes through the own-entry state only, and a received pair
// through the own-entry and pair states (own-entry only when its index is out of range), each
// giving one result for the own entry. A send to a valid peer goes on to a scan that reads one
// row of the clock memory per cycle, up to process_count rows (at most MAX_PROCESSES), and
// gives at most one result per cycle with the final one marked by last. Each result stands on
// the result port for one cycle while result_valid is high and cannot be held off. Registers
// are to be written only while busy is low and no result is due; the block itself does not
// enforce this. No clearing pass is needed after reset.
module differential_vector_clock (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  dvc_pkg::request_t                    request,
    output logic                                 busy,
    input  logic                                 cfg_write,
    input  logic [dvc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [dvc_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                 result_valid,
    output dvc_pkg::result_t                     result
);
    import dvc_pkg::*;

    localparam int STATE_W = 2;
    localparam logic [STATE_W-1:0] S_IDLE = 2'd0;
    localparam logic [STATE_W-1:0] S_OWN = 2'd1;
    localparam logic [STATE_W-1:0] S_PAIR = 2'd2;
    localparam logic [STATE_W-1:0] S_SCAN = 2'd3;

    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    index_t             own_index_reg;
    index_t             process_count_reg;
    request_t           req_reg;
    request_t           req_next;
    clock_t             own_val_reg;
    clock_t             own_val_next;
    clock_t             sent_reg;
    clock_t             sent_next;
    count_t             scan_cnt_reg;
    count_t             scan_cnt_next;
    count_t             scan_end_reg;
    count_t             scan_end_next;
    logic               rd_pend_reg;
    logic               rd_pend_next;
    addr_t              rd_addr_reg;
    addr_t              rd_addr_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    index_t             pend_index_reg;
    index_t             pend_index_next;
    clock_t             pend_value_reg;
    clock_t             pend_value_next;
    logic               result_valid_reg;
    logic               result_valid_next;
    result_t            result_reg;
    result_t            result_next;

    store_req_t         store_req;
    entry_t             a_rdata;
    clock_t             b_rdata;

    logic               own_ok;
    addr_t              own_addr;
    addr_t              pair_addr;
    logic               advance;
    logic               merge;
    logic               send_ok;
    logic               pair_ok;
    logic               forward;
    clock_t             own_cur;
    clock_t             own_new;
    clock_t             pair_cur;
    clock_t             merged_own;

    dvc_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .a_rdata (a_rdata),
        .b_rdata (b_rdata)
    );

    assign own_ok    = index_ok(own_index_reg);
    assign own_addr  = index_to_addr(own_index_reg);
    assign pair_addr = index_to_addr(req_reg.pair_index);
    assign advance   = (req_reg.kind != KIND_NEXT_PAIR);
    assign merge     = (req_reg.kind == KIND_FIRST_PAIR) || (req_reg.kind == KIND_NEXT_PAIR);
    assign send_ok   = (req_reg.kind == KIND_SEND) && index_ok(req_reg.peer_index);
    assign pair_ok   = index_ok(req_reg.pair_index);
    // The own row is written in the same cycle as the pair row is read.
    assign forward   = own_ok && (pair_addr == own_addr);

    always_comb
    begin
        state_next        = state_reg;
        req_next          = req_reg;
        own_val_next      = own_val_reg;
        sent_next         = sent_reg;
        scan_cnt_next     = scan_cnt_reg;
        scan_end_next     = scan_end_reg;
        rd_pend_next      = rd_pend_reg;
        rd_addr_next      = rd_addr_reg;
        pend_valid_next   = pend_valid_reg;
        pend_index_next   = pend_index_reg;
        pend_value_next   = pend_value_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        own_cur           = own_ok ? a_rdata.value : '0;
        own_new           = (advance && own_ok) ? sat_inc(own_cur) : own_cur;
        pair_cur          = forward ? own_val_reg : a_rdata.value;
        merged_own        = own_val_reg;

        store_req         = '0;
        store_req.a_raddr = own_addr;
        store_req.b_raddr = index_to_addr(request.peer_index);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = S_OWN;
                end
            end
            S_OWN:
            begin
                store_req.a_raddr = pair_addr;
                if (advance && own_ok)
                begin
                    store_req.a_we                = 1'b1;
                    store_req.a_waddr             = own_addr;
                    store_req.a_wdata.value       = own_new;
                    store_req.a_wdata.update_time = own_new;
                end
                own_val_next = own_new;
                sent_next    = b_rdata;
                if (send_ok)
                begin
                    scan_cnt_next   = '0;
                    scan_end_next   = count_limit(process_count_reg);
                    rd_pend_next    = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = S_SCAN;
                end
                else if (merge && pair_ok)
                begin
                    state_next = S_PAIR;
                end
                else
                begin
                    result_valid_next       = 1'b1;
                    result_next.entry_index = own_index_reg;
                    result_next.entry_value = own_new;
                    result_next.last        = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            S_PAIR:
            begin
                if (req_reg.pair_value > pair_cur)
                begin
                    merged_own                    = forward ? req_reg.pair_value : own_val_reg;
                    store_req.a_we                = 1'b1;
                    store_req.a_waddr             = pair_addr;
                    store_req.a_wdata.value       = req_reg.pair_value;
                    store_req.a_wdata.update_time = merged_own;
                end
                result_valid_next       = 1'b1;
                result_next.entry_index = own_index_reg;
                result_next.entry_value = merged_own;
                result_next.last        = 1'b1;
                state_next              = S_IDLE;
            end
            S_SCAN:
            begin
                store_req.a_raddr = scan_cnt_reg[ADDR_W-1:0];
                if (scan_cnt_reg != scan_end_reg)
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    rd_pend_next  = 1'b1;
                    rd_addr_next  = scan_cnt_reg[ADDR_W-1:0];
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
                // A changed entry is held back one match so that the final one can be marked.
                if (rd_pend_reg && (sent_reg < a_rdata.update_time))
                begin
                    if (pend_valid_reg)
                    begin
                        result_valid_next       = 1'b1;
                        result_next.entry_index = pend_index_reg;
                        result_next.entry_value = pend_value_reg;
                        result_next.last        = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_index_next = addr_to_index(rd_addr_reg);
                    pend_value_next = a_rdata.value;
                end
                if ((scan_cnt_reg == scan_end_reg) && !rd_pend_reg)
                begin
                    if (pend_valid_reg)
                    begin
                        result_valid_next       = 1'b1;
                        result_next.entry_index = pend_index_reg;
                        result_next.entry_value = pend_value_reg;
                        result_next.last        = 1'b1;
                    end
                    pend_valid_next   = 1'b0;
                    store_req.b_we    = 1'b1;
                    store_req.b_waddr = index_to_addr(req_reg.peer_index);
                    store_req.b_wdata = own_val_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            own_index_reg     <= OWN_INDEX_RESET;
            process_count_reg <= PROCESS_COUNT_RESET;
            scan_cnt_reg      <= '0;
            scan_end_reg      <= '0;
            rd_pend_reg       <= 1'b0;
            pend_valid_reg    <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_cnt_reg     <= scan_cnt_next;
            scan_end_reg     <= scan_end_next;
            rd_pend_reg      <= rd_pend_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_OWN_INDEX:
                    begin
                        own_index_reg <= cfg_data;
                    end
                    REG_PROCESS_COUNT:
                    begin
                        process_count_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        own_val_reg    <= own_val_next;
        sent_reg       <= sent_next;
        rd_addr_reg    <= rd_addr_next;
        pend_index_reg <= pend_index_next;
        pend_value_reg <= pend_value_next;
        result_reg     <= result_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted request did not make the block busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy)
        else $error("Final result shown while the block is still busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> busy)
        else $error("Intermediate result shown after the scan ended.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (!store_req.a_we && !store_req.b_we))
        else $error("Memory written while the block is idle.");

endmodule
